// File: rtl/vgti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vgti_pkg;

    // query kinds
    typedef enum logic [2:0] {
        REQ_VERTEX = 3'd0,
        REQ_EDGE   = 3'd1,
        REQ_FACE   = 3'd2,
        REQ_CELL   = 3'd3,
        REQ_P2I    = 3'd4
    } t_req;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam int MAX_GRID_SIDE = 1024;
    localparam int MAX_LOG       = $clog2(MAX_GRID_SIDE);
    localparam int CFG_W         = 4;
    localparam logic [CFG_W-1:0] CFG_RESET = 4'd4;

    localparam int COORD_W = 11;
    localparam int IDX_W   = 31;
    localparam int QW      = MAX_LOG + 1;   // quotient digit width
    localparam int NST     = 12;            // pipeline stages
    localparam int IN_TDATA_W  = 64;
    localparam int IN_TUSER_W  = 5;
    localparam int OUT_TDATA_W = 200;

    // grid geometry derived from the log size register
    typedef struct packed {
        logic [3:0]  k;
        logic [10:0] h;
        logic [10:0] n;
        logic [20:0] n2;
        logic [30:0] n3;
    } t_geom;

    function automatic t_geom geo_of(input logic [CFG_W-1:0] lg);
        t_geom       g;
        logic [3:0]  k;
        logic [31:0] s;
        logic [31:0] n2;
        logic [31:0] n3;
        k = lg;
        if (k < 4'd1) begin
            k = 4'd1;
        end
        if (k > 4'(MAX_LOG)) begin
            k = 4'(MAX_LOG);
        end
        s  = 32'd1 << k;
        n2 = (s << k) + (s << 1) + 32'd1;
        n3 = (n2 << k) + n2;
        g.k  = k;
        g.h  = 11'(s >> 1);
        g.n  = 11'(s + 32'd1);
        g.n2 = 21'(n2);
        g.n3 = 31'(n3);
        return g;
    endfunction

    // one pipeline stage
    typedef struct packed {
        logic               is_idx;
        logic               is_edge;
        logic               is_p2i;
        logic               ing;
        logic               brd;
        logic [1:0]         axis;
        logic [10:0]        ux;
        logic [10:0]        uy;
        logic [10:0]        uz;
        logic [3:0]         emask;
        logic [IDX_W-1:0]   acc;
        logic [3:0][IDX_W-1:0] cells;
        logic [3:0]         cvalid;
        logic [IDX_W-1:0]   rem;
        logic [QW-1:0]      qy;
        logic [QW-1:0]      qx;
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] oz;
    } t_stage;

endpackage
`default_nettype wire

// File: rtl/voxel_grid_topology_indexer.sv
// Grid topology query unit for a centered cubic grid of side 2^k cells.
// Input stream (s_axis_*): one query per transaction; tuser carries the
// query kind and axis, tdata the position and linear index.
// Output stream (m_axis_*): one result per query, same order.
// Config channel (i_cfg_*): writes grid_log_size; always ready. Write it
// only while no query is in flight.
// Pipeline: 12 stages; 11 of them carry the restoring division of the
// linear index by (side+1)^2 and then by side+1
// (two quotient bits per stage) for the index-to-point query.
// Throughput: one query per cycle sustained while the output is not stalled.
// Reset: clears all stage valid bits and sets grid_log_size to 4.
// Stall: when m_axis_tready is low with a result waiting, the whole
// pipeline holds and s_axis_tready drops; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module voxel_grid_topology_indexer (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [vgti_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // pos_x[10:0], pos_y[21:11], pos_z[32:22], lin_index[63:33]
    input  wire logic [vgti_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // req_type[2:0], axis[4:3]
    input  wire logic [vgti_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // in_grid[0], on_border[1], point_index[32:2], cell_a[63:33],
    // cell_b[94:64], cell_c[125:95], cell_d[156:126], cell_valid[160:157],
    // out_x[171:161], out_y[182:172], out_z[193:183], zero[199:194]
    output logic [vgti_pkg::OUT_TDATA_W-1:0]       m_axis_tdata
);
    import vgti_pkg::*;

    logic [CFG_W-1:0] r_cfg;
    t_geom            w_geo;
    logic             w_adv;
    logic [NST-1:0]   r_vld;
    t_stage           r_pipe [NST];
    t_stage           n_pipe [NST];

    // config register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    assign w_geo = geo_of(r_cfg);

    // global pipeline advance
    assign w_adv         = !r_vld[NST-1] || m_axis_tready;
    assign s_axis_tready = w_adv;

    // stage 0: decode, range checks, offsets, edge mask
    always_comb begin
        logic signed [11:0] p [3];
        logic signed [11:0] hh;
        logic [2:0]  inc, ho, eqh, cb, lo, hi;
        logic [1:0]  ax;
        logic [2:0]  rq;
        logic [30:0] li;
        logic [1:0]  ia, ib;
        logic [3:0]  m;
        t_stage      st;
        p[0] = $signed({s_axis_tdata[10], s_axis_tdata[10:0]});
        p[1] = $signed({s_axis_tdata[21], s_axis_tdata[21:11]});
        p[2] = $signed({s_axis_tdata[32], s_axis_tdata[32:22]});
        li   = s_axis_tdata[63:33];
        rq   = s_axis_tuser[2:0];
        ax   = s_axis_tuser[4:3];
        hh   = $signed({1'b0, w_geo.h});
        for (int i = 0; i < 3; i++) begin
            inc[i] = (p[i] >= -hh) && (p[i] <= hh);
            ho[i]  = (p[i] >= -hh) && (p[i] < hh);
            lo[i]  = (p[i] == -hh);
            hi[i]  = (p[i] == hh);
            eqh[i] = lo[i] || hi[i];
            cb[i]  = lo[i] || (p[i] == hh - 12'sd1);
        end
        // axes across the edge / in the face plane
        case (ax)
            AXIS_X: begin ia = AXIS_Y; ib = AXIS_Z; end
            AXIS_Y: begin ia = AXIS_Z; ib = AXIS_X; end
            default: begin ia = AXIS_X; ib = AXIS_Y; end
        endcase
        st = '0;
        st.axis = ax;
        st.ux = 11'(p[0] + hh);
        st.uy = 11'(p[1] + hh);
        st.uz = 11'(p[2] + hh);
        st.rem = li;
        case (rq)
            REQ_VERTEX: begin
                st.is_idx = 1'b1;
                st.ing = &inc;
                st.brd = |eqh;
            end
            REQ_EDGE: begin
                if (ax != 2'd3) begin
                    st.is_idx  = 1'b1;
                    st.is_edge = 1'b1;
                    st.ing = ho[ax] && inc[ia] && inc[ib];
                    st.brd = eqh[ia] || eqh[ib];
                end
            end
            REQ_FACE: begin
                if (ax != 2'd3) begin
                    st.is_idx = 1'b1;
                    st.ing = inc[ax] && ho[ia] && ho[ib];
                    st.brd = eqh[ax];
                end
            end
            REQ_CELL: begin
                st.is_idx = 1'b1;
                st.ing = &ho;
                st.brd = |cb;
            end
            REQ_P2I: begin
                st.is_p2i = (li < w_geo.n3);
                st.ing = st.is_p2i;
                st.acc = li;
            end
            default: begin
                st.ing = 1'b0;
            end
        endcase
        // adjacent cell mask
        m = 4'hF;
        case (ax)
            AXIS_X: begin
                if (lo[1]) m &= ~4'h9;
                if (hi[1]) m &= ~4'h6;
                if (lo[2]) m &= ~4'h3;
                if (hi[2]) m &= ~4'hC;
            end
            AXIS_Y: begin
                if (lo[0]) m &= ~4'h3;
                if (hi[0]) m &= ~4'hC;
                if (lo[2]) m &= ~4'h9;
                if (hi[2]) m &= ~4'h6;
            end
            default: begin
                if (lo[0]) m &= ~4'h9;
                if (hi[0]) m &= ~4'h6;
                if (lo[1]) m &= ~4'h3;
                if (hi[1]) m &= ~4'hC;
            end
        endcase
        st.emask = m;
        n_pipe[0] = st;
    end

    // stages 1..NST-1: index build, cells, two division steps each
    always_comb begin
        t_stage      st;
        logic [31:0] dv;
        logic [31:0] rm;
        logic [30:0] n31, n231, o0, o1, o3;
        int          si;
        n31  = 31'(w_geo.n);
        n231 = 31'(w_geo.n2);
        o0   = '0;
        o1   = '0;
        o3   = '0;
        for (int s = 1; s < NST; s++) begin
            st = r_pipe[s-1];
            // restoring division: y digits by n^2, then x digits by n
            for (int j = 0; j < 2; j++) begin
                si = 2 * (s - 1) + j;
                if (si < QW) begin
                    dv = {11'd0, w_geo.n2} << (QW - 1 - si);
                end else begin
                    dv = {21'd0, w_geo.n} << (2 * QW - 1 - si);
                end
                rm = {1'b0, st.rem};
                if (rm >= dv) begin
                    st.rem = 31'(rm - dv);
                    if (si < QW) begin
                        st.qy[QW-1-si] = 1'b1;
                    end else begin
                        st.qx[2*QW-1-si] = 1'b1;
                    end
                end
            end
            // linear index: ((y+h)*n + (x+h))*n + (z+h)
            if (s == 1 && st.is_idx) begin
                st.acc = (31'(st.uy) << w_geo.k) + 31'(st.uy) + 31'(st.ux);
            end
            if (s == 2 && st.is_idx) begin
                st.acc = (st.acc << w_geo.k) + st.acc + 31'(st.uz);
            end
            // adjacent cells of an edge
            if (s == 3) begin
                case (st.axis)
                    AXIS_X: begin o0 = n231 + 31'd1; o1 = 31'd1; o3 = n231; end
                    AXIS_Y: begin o0 = n31 + 31'd1; o1 = n31; o3 = 31'd1; end
                    default: begin o0 = n31 + n231; o1 = n231; o3 = n31; end
                endcase
                if (!st.ing) begin
                    st.acc = '0;
                end
                st.cvalid = (st.ing && st.is_edge) ? st.emask : 4'h0;
                st.cells[0] = st.cvalid[0] ? st.acc - o0 : '0;
                st.cells[1] = st.cvalid[1] ? st.acc - o1 : '0;
                st.cells[2] = st.cvalid[2] ? st.acc : '0;
                st.cells[3] = st.cvalid[3] ? st.acc - o3 : '0;
            end
            // point recovery from the quotient digits
            if (s == NST - 1) begin
                if (st.is_p2i) begin
                    st.ox = 11'(st.qx) - w_geo.h;
                    st.oy = 11'(st.qy) - w_geo.h;
                    st.oz = 11'(st.rem) - w_geo.h;
                    st.brd = (st.qx == '0) || (st.qx == QW'({w_geo.h, 1'b0})) ||
                             (st.qy == '0) || (st.qy == QW'({w_geo.h, 1'b0})) ||
                             (st.rem == '0) || (st.rem == IDX_W'({w_geo.h, 1'b0}));
                end else begin
                    st.ox = '0;
                    st.oy = '0;
                    st.oz = '0;
                end
            end
            n_pipe[s] = st;
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], s_axis_tvalid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int s = 0; s < NST; s++) begin
                r_pipe[s] <= n_pipe[s];
            end
        end
    end

    // result packing
    assign m_axis_tvalid = r_vld[NST-1];
    assign m_axis_tdata  = {6'd0,
                            r_pipe[NST-1].oz,
                            r_pipe[NST-1].oy,
                            r_pipe[NST-1].ox,
                            r_pipe[NST-1].cvalid,
                            r_pipe[NST-1].cells[3],
                            r_pipe[NST-1].cells[2],
                            r_pipe[NST-1].cells[1],
                            r_pipe[NST-1].cells[0],
                            r_pipe[NST-1].acc,
                            r_pipe[NST-1].brd,
                            r_pipe[NST-1].ing};

    // checks
    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[32:2] == '0))
        else $error("index set on out-of-grid result");
    a_cells_ing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[160:157] != 4'h0)) |-> m_axis_tdata[0])
        else $error("cell mask set on out-of-grid result");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_vld))
        else $error("pipeline moved during stall");

endmodule
`default_nettype wire
